### rtl/core/pts_pkg.sv
// shared constants and types of the priority time-slice scheduler
`default_nettype none
package pts_pkg;

	localparam int SOURCES   = 16;
	localparam int SRC_W     = 4;
	localparam int TIME_W    = 32;
	localparam int PRIO_W    = 8;
	localparam int TAG_W     = 16;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_SLICE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLICE  = 1'd1;

	localparam logic [TIME_W-1:0] TIME_SLICE_RST = 32'd1000;
	localparam logic [TIME_W-1:0] MIN_SLICE_RST  = 32'd0;

	// running candidate of one frame
	typedef struct packed {
		logic              valid;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] rtime;
		logic [SRC_W-1:0]  src;
		logic [TAG_W-1:0]  tag;
		logic [TIME_W-1:0] len;
	} cand_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic decide;
	} cmd_t;

endpackage
`default_nettype wire

### rtl/core/pts_rpt_if.sv
// source report channel
`default_nettype none
interface pts_rpt_if;
	logic                            valid;
	logic                            ready;
	logic [pts_pkg::SRC_W-1:0]       source_index;
	logic                            has_work;
	logic [pts_pkg::TIME_W-1:0]      runnable_time;
	logic [pts_pkg::PRIO_W-1:0]      prio_level;
	logic [pts_pkg::TAG_W-1:0]       trans_tag;
	logic [pts_pkg::TIME_W-1:0]      op_length;
	logic [pts_pkg::TIME_W-1:0]      end_schedule;
	logic                            last_report;

	modport source (
		output valid, source_index, has_work, runnable_time, prio_level,
		       trans_tag, op_length, end_schedule, last_report,
		input  ready
	);
	modport sink (
		input  valid, source_index, has_work, runnable_time, prio_level,
		       trans_tag, op_length, end_schedule, last_report,
		output ready
	);
endinterface
`default_nettype wire

### rtl/core/pts_rslt_if.sv
// scheduling decision channel
`default_nettype none
interface pts_rslt_if;
	logic                       valid;
	logic                       ready;
	logic                       found;
	logic [pts_pkg::SRC_W-1:0]  chosen_source;
	logic [pts_pkg::TAG_W-1:0]  chosen_tag;
	logic                       kept_same;
	logic [pts_pkg::TIME_W-1:0] slice_left;

	modport source (
		output valid, found, chosen_source, chosen_tag, kept_same, slice_left,
		input  ready
	);
	modport sink (
		input  valid, found, chosen_source, chosen_tag, kept_same, slice_left,
		output ready
	);
endinterface
`default_nettype wire

### rtl/core/pts_ctrl.sv
// frame controller: collects reports, then makes the frame's decision
`default_nettype none
module pts_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rpt_valid,
	input  wire logic          rpt_last,
	input  wire logic          rslt_ready,
	output logic               rpt_ready,
	output logic               rslt_valid,
	output pts_pkg::cmd_t      cmd
);

	localparam logic [0:0] ST_COLLECT = 1'b0;
	localparam logic [0:0] ST_DECIDE  = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_nxt;
	logic       out_valid_q;

	assign rpt_ready  = (state_q == ST_COLLECT);
	assign rslt_valid = out_valid_q;

	always_comb begin
		cmd.load   = rpt_valid && rpt_ready;
		cmd.decide = (state_q == ST_DECIDE) && (!out_valid_q || rslt_ready);
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_COLLECT: begin
				if (cmd.load && rpt_last) state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (cmd.decide) state_nxt = ST_COLLECT;
			end
			default: state_nxt = ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.decide)      out_valid_q <= 1'b1;
			else if (rslt_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

### rtl/core/pts_datapath.sv
// candidate registers, slice bookkeeping and result register
`default_nettype none
module pts_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pts_pkg::cmd_t                       cmd,
	input  wire logic                                cfg_we,
	input  wire logic [pts_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pts_pkg::TIME_W-1:0]          cfg_wdata,
	input  wire logic [pts_pkg::SRC_W-1:0]           source_index,
	input  wire logic                                has_work,
	input  wire logic [pts_pkg::TIME_W-1:0]          runnable_time,
	input  wire logic [pts_pkg::PRIO_W-1:0]          prio_level,
	input  wire logic [pts_pkg::TAG_W-1:0]           trans_tag,
	input  wire logic [pts_pkg::TIME_W-1:0]          op_length,
	input  wire logic [pts_pkg::TIME_W-1:0]          end_schedule,
	output logic                                     found,
	output logic [pts_pkg::SRC_W-1:0]                chosen_source,
	output logic [pts_pkg::TAG_W-1:0]                chosen_tag,
	output logic                                     kept_same,
	output logic [pts_pkg::TIME_W-1:0]               slice_left
);

	localparam int TW = pts_pkg::TIME_W;

	logic [TW-1:0]                 time_slice_q;
	logic [TW-1:0]                 min_slice_q;
	logic [TW-1:0]                 elapsed_q;
	logic                          prev_valid_q;
	logic [pts_pkg::SRC_W-1:0]     prev_source_q;
	logic                          old_valid_q;
	logic [pts_pkg::TAG_W-1:0]     old_tag_q;
	logic [TW-1:0]                 old_length_q;
	pts_pkg::cand_t                past_q;
	pts_pkg::cand_t                future_q;
	logic                          sticky_valid_q;
	logic [pts_pkg::TAG_W-1:0]     sticky_tag_q;
	logic [TW-1:0]                 sticky_len_q;

	logic                          rpt_ok;
	logic                          is_past;
	logic                          past_win;
	logic                          future_win;
	logic                          sticky_hit;
	pts_pkg::cand_t                cand;

	logic [TW+1:0]                 need;
	logic [TW:0]                   sum;
	logic [TW-1:0]                 sum_sat;
	logic                          keep;
	logic                          sel_found;
	logic [pts_pkg::SRC_W-1:0]     sel_src;
	logic [pts_pkg::TAG_W-1:0]     sel_tag;
	logic [TW-1:0]                 sel_len;
	logic [TW-1:0]                 elapsed_nxt;

	// report compares
	always_comb begin
		rpt_ok     = has_work && (32'(source_index) < pts_pkg::SOURCES);
		is_past    = (runnable_time <= end_schedule);
		past_win   = !past_q.valid || (prio_level < past_q.prio) ||
		             ((prio_level == past_q.prio) && (runnable_time < past_q.rtime));
		future_win = !future_q.valid || (runnable_time < future_q.rtime);
		sticky_hit = rpt_ok && prev_valid_q && (source_index == prev_source_q);
		cand.valid = 1'b1;
		cand.prio  = prio_level;
		cand.rtime = runnable_time;
		cand.src   = source_index;
		cand.tag   = trans_tag;
		cand.len   = op_length;
	end

	// decision
	always_comb begin
		need    = {2'b00, elapsed_q} + {2'b00, old_length_q} + {2'b00, min_slice_q};
		sum     = {1'b0, elapsed_q} + {1'b0, old_length_q};
		sum_sat = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
		keep    = prev_valid_q && sticky_valid_q &&
		          (!old_valid_q || (sticky_tag_q == old_tag_q) ||
		           ({2'b00, time_slice_q} >= need));

		sel_found = 1'b0;
		sel_src   = '0;
		sel_tag   = '0;
		sel_len   = '0;
		priority if (keep) begin
			sel_found = 1'b1;
			sel_src   = prev_source_q;
			sel_tag   = sticky_tag_q;
			sel_len   = sticky_len_q;
		end else if (past_q.valid) begin
			sel_found = 1'b1;
			sel_src   = past_q.src;
			sel_tag   = past_q.tag;
			sel_len   = past_q.len;
		end else if (future_q.valid) begin
			sel_found = 1'b1;
			sel_src   = future_q.src;
			sel_tag   = future_q.tag;
			sel_len   = future_q.len;
		end

		if (!keep)                                         elapsed_nxt = '0;
		else if (old_valid_q && (sticky_tag_q != old_tag_q)) elapsed_nxt = sum_sat;
		else                                               elapsed_nxt = elapsed_q;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_slice_q <= pts_pkg::TIME_SLICE_RST;
			min_slice_q  <= pts_pkg::MIN_SLICE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pts_pkg::CFG_TIME_SLICE: time_slice_q <= cfg_wdata;
				pts_pkg::CFG_MIN_SLICE:  min_slice_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// frame and scheduling state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q      <= '0;
			prev_valid_q   <= 1'b0;
			prev_source_q  <= '0;
			old_valid_q    <= 1'b0;
			old_tag_q      <= '0;
			old_length_q   <= '0;
			past_q         <= '0;
			future_q       <= '0;
			sticky_valid_q <= 1'b0;
			sticky_tag_q   <= '0;
			sticky_len_q   <= '0;
		end else if (cmd.decide) begin
			elapsed_q      <= elapsed_nxt;
			prev_valid_q   <= sel_found;
			prev_source_q  <= sel_src;
			old_valid_q    <= sel_found;
			old_tag_q      <= sel_tag;
			old_length_q   <= sel_len;
			past_q         <= '0;
			future_q       <= '0;
			sticky_valid_q <= 1'b0;
			sticky_tag_q   <= '0;
			sticky_len_q   <= '0;
		end else if (cmd.load && rpt_ok) begin
			if (sticky_hit) begin
				sticky_valid_q <= 1'b1;
				sticky_tag_q   <= trans_tag;
				sticky_len_q   <= op_length;
			end
			if (is_past && past_win)    past_q   <= cand;
			if (!is_past && future_win) future_q <= cand;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			found         <= sel_found;
			chosen_source <= sel_src;
			chosen_tag    <= sel_tag;
			kept_same     <= keep;
			slice_left    <= time_slice_q - elapsed_nxt;
		end
	end

endmodule
`default_nettype wire

### rtl/core/priority_time_slice_scheduler_top.sv
// top level of the priority time-slice scheduler
// the last report moves the controller to its decide state, which loads the result register
// reports: one report per cycle while the controller collects; none are taken while it decides
// the decision cycle waits while the previous result has not been taken
// reset: arst_n clears the slice state and frame candidates, time_slice = 1000, min_slice = 0
`default_nettype none
module priority_time_slice_scheduler_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [pts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pts_pkg::TIME_W-1:0]     cfg_wdata,
	pts_rpt_if.sink                             rpt,
	pts_rslt_if.source                          rslt
);

	pts_pkg::cmd_t cmd;

	// controller: report acceptance, decision timing, result valid
	pts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.rpt_valid  (rpt.valid),
		.rpt_last   (rpt.last_report),
		.rslt_ready (rslt.ready),
		.rpt_ready  (rpt.ready),
		.rslt_valid (rslt.valid),
		.cmd        (cmd)
	);

	// datapath: running best candidates per frame, keep test, elapsed time
	pts_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.source_index  (rpt.source_index),
		.has_work      (rpt.has_work),
		.runnable_time (rpt.runnable_time),
		.prio_level    (rpt.prio_level),
		.trans_tag     (rpt.trans_tag),
		.op_length     (rpt.op_length),
		.end_schedule  (rpt.end_schedule),
		.found         (rslt.found),
		.chosen_source (rslt.chosen_source),
		.chosen_tag    (rslt.chosen_tag),
		.kept_same     (rslt.kept_same),
		.slice_left    (rslt.slice_left)
	);

	// a frame end transaction blocks reports for the decision cycle
	a_decide_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(rpt.valid && rpt.ready && rpt.last_report) |=> !rpt.ready)
		else $error("report accepted in decision cycle");

	// nothing found means no source, no tag and no keep
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(rslt.valid && !rslt.found) |->
		(rslt.chosen_source == '0 && rslt.chosen_tag == '0 && !rslt.kept_same))
		else $error("empty decision carries a selection");

	// a decision never replaces a result that is still waiting
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |-> (!rslt.valid || rslt.ready))
		else $error("decision overwrote an untaken result");

endmodule
`default_nettype wire
